// ===== rtl/sft_pkg.sv =====
`default_nettype none

package sft_pkg;

  // Request codes carried in the input tuser
  typedef enum logic [1:0] {
    REQ_COUNT = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned ENTRY_W = 8;
  localparam int unsigned DCNT_W  = 9;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned FLAG_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Control part of the word that walks down the cell chain
  typedef struct packed {
    logic valid;
    req_e req;
    logic hit;    // symbol found in an earlier cell
    logic fresh;  // symbol appended by an earlier cell
  } sft_tok_t;

  // Saturating increment for occurrence and total counts
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == CNT_MAX) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sft_cell.sv =====
`default_nettype none

module sft_cell #(
  parameter int unsigned SYMBOL_BITS = 21,
  parameter int unsigned IDX_W       = 8,
  parameter int unsigned DIST_W      = 9,
  parameter int unsigned CELL_INDEX  = 0
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   adv_i,
  input  wire  [DIST_W-1:0]     distinct_i,
  input  sft_pkg::sft_tok_t     tok_i,
  input  wire  [SYMBOL_BITS-1:0] sym_i,
  input  wire  [IDX_W-1:0]      idx_i,
  input  wire  [sft_pkg::CNT_W-1:0] occ_i,
  output sft_pkg::sft_tok_t     tok_o,
  output logic [SYMBOL_BITS-1:0] sym_o,
  output logic [IDX_W-1:0]      idx_o,
  output logic [sft_pkg::CNT_W-1:0] occ_o
);
  import sft_pkg::*;

  localparam logic [DIST_W-1:0] MY_POS = CELL_INDEX[DIST_W-1:0];
  localparam logic [IDX_W-1:0]  MY_IDX = CELL_INDEX[IDX_W-1:0];

  // Entry held by this cell
  logic [SYMBOL_BITS-1:0] sym_q, sym_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  // Word register toward the next cell
  sft_tok_t               tok_q, tok_d;
  logic [SYMBOL_BITS-1:0] wsym_q, wsym_d;
  logic [IDX_W-1:0]       widx_q, widx_d;
  logic [CNT_W-1:0]       wocc_q, wocc_d;

  logic used, is_count, match, append, rd;
  logic [CNT_W-1:0] cnt_inc;

  // Match, append and read decisions
  assign used     = MY_POS < distinct_i;
  assign is_count = tok_i.valid && (tok_i.req == REQ_COUNT);
  assign match    = is_count && !tok_i.hit && used && (sym_q == sym_i);
  assign append   = is_count && !tok_i.hit && !tok_i.fresh && (MY_POS == distinct_i);
  assign rd       = tok_i.valid && (tok_i.req == REQ_READ) && used && (idx_i == MY_IDX);
  assign cnt_inc  = sat_inc(cnt_q);

  always_comb begin
    sym_d  = sym_q;
    cnt_d  = cnt_q;
    tok_d  = tok_i;
    wsym_d = sym_i;
    widx_d = idx_i;
    wocc_d = occ_i;
    if (match) begin
      cnt_d     = cnt_inc;
      tok_d.hit = 1'b1;
      widx_d    = MY_IDX;
      wocc_d    = cnt_inc;
    end else if (append) begin
      sym_d       = sym_i;
      cnt_d       = {{(CNT_W-1){1'b0}}, 1'b1};
      tok_d.fresh = 1'b1;
      widx_d      = MY_IDX;
      wocc_d      = {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (rd) begin
      wsym_d = sym_q;
      wocc_d = cnt_q;
    end
  end

  // Control bits of the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  // Entry and payload, no reset
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sym_q  <= sym_d;
      cnt_q  <= cnt_d;
      wsym_q <= wsym_d;
      widx_q <= widx_d;
      wocc_q <= wocc_d;
    end
  end

  assign tok_o = tok_q;
  assign sym_o = wsym_q;
  assign idx_o = widx_q;
  assign occ_o = wocc_q;

endmodule

`default_nettype wire

// ===== rtl/symbol_frequency_table_unit.sv =====
`default_nettype none

// Each request walks the full cell chain, one cell per cycle unless stalled,
// and the next one is taken only once it has left the chain. A result
// still held in the output register stalls the chain until it is taken.
// Reset: asynchronous, active low; clears the distinct and total counts and
// the handshake state. Entry contents are not cleared and need no sweep.

module symbol_frequency_table_unit #(
  parameter int unsigned MAX_SYMBOLS = 256,
  parameter int unsigned SYMBOL_BITS = 21,
  localparam int unsigned IN_W  = ((SYMBOL_BITS + 8 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((SYMBOL_BITS + 81 + 7) / 8) * 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  [IN_W-1:0]   s_axis_tdata,  // symbol, read_index
  input  wire  [1:0]        s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,  // entry_index, symbol_value, occurrences,
                                           // distinct_count, total_count
  output logic [1:0]        m_axis_tuser   // is_new, table_full
);
  import sft_pkg::*;

  localparam int unsigned IW     = $clog2(MAX_SYMBOLS);
  localparam int unsigned XW     = (IW > ENTRY_W) ? IW : ENTRY_W;
  localparam int unsigned DIST_W = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned PAD_W  = OUT_W - (SYMBOL_BITS + 81);

  // Chain nodes: node 0 is the head, node k+1 is the output of cell k
  sft_tok_t               tok_n [MAX_SYMBOLS+1];
  logic [SYMBOL_BITS-1:0] sym_n [MAX_SYMBOLS+1];
  logic [XW-1:0]          idx_n [MAX_SYMBOLS+1];
  logic [CNT_W-1:0]       occ_n [MAX_SYMBOLS+1];

  logic                   busy_q, busy_d;
  logic [DIST_W-1:0]      dist_q, dist_d;
  logic [CNT_W-1:0]       total_q, total_d;
  logic                   mval_q, mval_d;
  logic [OUT_W-1:0]       mdata_q, mdata_d;
  logic [1:0]             muser_q, muser_d;

  logic s_fire, adv, load;
  req_e in_req;
  sft_tok_t tail;
  logic [DIST_W+DCNT_W-1:0] dist_wide;
  logic [DCNT_W-1:0] dist_out;
  logic is_new, full;

  // Input side
  assign s_axis_tready = !busy_q;
  assign s_fire        = s_axis_tvalid && !busy_q;
  assign in_req        = req_e'(s_axis_tuser);

  // Head of chain: build the walking word
  always_comb begin
    tok_n[0]       = '0;
    tok_n[0].valid = s_fire;
    tok_n[0].req   = in_req;
    sym_n[0]       = (in_req == REQ_COUNT) ? s_axis_tdata[SYMBOL_BITS-1:0] : '0;
    idx_n[0]       = '0;
    if (in_req == REQ_READ) begin
      idx_n[0][ENTRY_W-1:0] = s_axis_tdata[SYMBOL_BITS +: ENTRY_W];
    end
    occ_n[0]       = '0;
  end

  // Chain stalls only while a finished word waits on a full output register
  assign tail = tok_n[MAX_SYMBOLS];
  assign adv  = !(tail.valid && mval_q && !m_axis_tready);
  assign load = tail.valid && adv;

  // Row of cells
  for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_cell
    sft_cell #(
      .SYMBOL_BITS (SYMBOL_BITS),
      .IDX_W       (XW),
      .DIST_W      (DIST_W),
      .CELL_INDEX  (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .distinct_i (dist_q),
      .tok_i      (tok_n[k]),
      .sym_i      (sym_n[k]),
      .idx_i      (idx_n[k]),
      .occ_i      (occ_n[k]),
      .tok_o      (tok_n[k+1]),
      .sym_o      (sym_n[k+1]),
      .idx_o      (idx_n[k+1]),
      .occ_o      (occ_n[k+1])
    );
  end

  // Count updates when the word leaves the chain
  assign is_new = (tail.req == REQ_COUNT) && tail.fresh;
  assign full   = (tail.req == REQ_COUNT) && !tail.hit && !tail.fresh;

  always_comb begin
    dist_d  = dist_q;
    total_d = total_q;
    if (load) begin
      case (tail.req)
        REQ_COUNT: begin
          if (tail.fresh) begin
            dist_d = dist_q + 1'b1;
          end
          if (tail.hit || tail.fresh) begin
            total_d = sat_inc(total_q);
          end
        end
        REQ_CLEAR: begin
          dist_d  = '0;
          total_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign dist_wide = {{DCNT_W{1'b0}}, dist_d};
  assign dist_out  = dist_wide[DCNT_W-1:0];

  // Output register
  always_comb begin
    mval_d  = mval_q && !m_axis_tready;
    mdata_d = mdata_q;
    muser_d = muser_q;
    busy_d  = busy_q;
    if (s_fire) begin
      busy_d = 1'b1;
    end
    if (load) begin
      mval_d  = 1'b1;
      busy_d  = 1'b0;
      mdata_d = {{PAD_W{1'b0}}, total_d, dist_out, occ_n[MAX_SYMBOLS],
                 sym_n[MAX_SYMBOLS], idx_n[MAX_SYMBOLS][ENTRY_W-1:0]};
      muser_d = {full, is_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      mval_q  <= 1'b0;
      dist_q  <= '0;
      total_q <= '0;
    end else begin
      busy_q  <= busy_d;
      mval_q  <= mval_d;
      dist_q  <= dist_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mdata_q <= mdata_d;
    muser_q <= muser_d;
  end

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

endmodule

`default_nettype wire

// ===== verif/symbol_frequency_table_unit_tb.sv =====
`default_nettype none

module symbol_frequency_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sft_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned SYM_W       = 21;
  localparam int unsigned IN_W        = ((SYM_W + 8 + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((SYM_W + 81 + 7) / 8) * 8;
  localparam int unsigned ITEM_TARGET = 1750;

  // Output tdata layout, lowest bit first
  localparam int unsigned ENT_LSB  = 0;
  localparam int unsigned SYM_LSB  = ENT_LSB + ENTRY_W;
  localparam int unsigned OCC_LSB  = SYM_LSB + SYM_W;
  localparam int unsigned DCNT_LSB = OCC_LSB + CNT_W;
  localparam int unsigned TOT_LSB  = DCNT_LSB + DCNT_W;

  // Request code the block does not know; must leave state alone
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // Receiver pacing modes
  localparam int PACE_FREE   = 0;
  localparam int PACE_HALF   = 1;
  localparam int PACE_SPARSE = 2;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic               is_new;
    logic               table_full;
    logic [SYM_W-1:0]   symbol_value;
    logic [CNT_W-1:0]   occurrences;
    logic [DCNT_W-1:0]  distinct_count;
    logic [CNT_W-1:0]   total_count;
  } freq_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [SYM_W-1:0]   sym;
    logic [ENTRY_W-1:0] idx;
    logic               typed;      // hand-written result below applies
    freq_result_t       typed_res;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;   // symbol, read_index
  logic [1:0]        s_axis_tuser = '0;   // req_type
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;        // entry_index, symbol_value, occurrences,
                                          // distinct_count, total_count
  logic [1:0]        m_axis_tuser;        // is_new, table_full

  // Travel alongside the word so the monitor knows which result to expect
  logic              word_typed = 1'b0;
  freq_result_t      word_res = '0;

  symbol_frequency_table_unit #(
    .MAX_SYMBOLS(TABLE_DEPTH),
    .SYMBOL_BITS(SYM_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the frequency table
  logic [SYM_W-1:0] sym_tab [TABLE_DEPTH];
  logic [CNT_W-1:0] cnt_tab [TABLE_DEPTH];
  int unsigned      n_distinct = 0;
  logic [CNT_W-1:0] n_total = '0;

  freq_result_t     pending_q [$];
  int               errors = 0;
  int               sent_words = 0;
  int               burst_left = 1;

  // Coverage tallies for the summary
  int n_count_req = 0, n_read_req = 0, n_clear_req = 0, n_other_req = 0;
  int n_new = 0, n_full = 0, n_results = 0, peak_distinct = 0;

  function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Apply one request to the shadow table and return the result it gives
  function automatic freq_result_t tally_request(input logic [REQ_W-1:0] req,
                                                 input logic [SYM_W-1:0] sym,
                                                 input logic [ENTRY_W-1:0] idx);
    freq_result_t r;
    int           hit;
    r   = '0;
    hit = -1;
    case (req)
      REQ_COUNT: begin
        for (int i = 0; i < n_distinct; i++)
          if (hit < 0 && sym_tab[i] == sym) hit = i;
        r.symbol_value = sym;
        if (hit >= 0) begin
          cnt_tab[hit]  = bump_sat(cnt_tab[hit]);
          n_total       = bump_sat(n_total);
          r.entry_index = hit[ENTRY_W-1:0];
          r.occurrences = cnt_tab[hit];
        end else if (n_distinct == TABLE_DEPTH) begin
          // full: the new symbol is dropped, nothing changes
          r.table_full = 1'b1;
        end else begin
          sym_tab[n_distinct] = sym;
          cnt_tab[n_distinct] = 1;
          r.entry_index       = n_distinct[ENTRY_W-1:0];
          r.is_new            = 1'b1;
          r.occurrences       = 1;
          n_distinct++;
          n_total = bump_sat(n_total);
        end
      end
      REQ_READ: begin
        r.entry_index = idx;
        if (idx < n_distinct) begin
          r.symbol_value = sym_tab[idx];
          r.occurrences  = cnt_tab[idx];
        end
      end
      REQ_CLEAR: begin
        n_distinct = 0;
        n_total    = '0;
      end
      default: ;
    endcase
    r.distinct_count = n_distinct[DCNT_W-1:0];
    r.total_count    = n_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Monitor: predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    freq_result_t pred, want, got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = tally_request(s_axis_tuser, s_axis_tdata[SYM_W-1:0],
                             s_axis_tdata[SYM_W +: ENTRY_W]);
        pending_q.push_back(word_typed ? word_res : pred);
        case (s_axis_tuser)
          REQ_COUNT: n_count_req++;
          REQ_READ:  n_read_req++;
          REQ_CLEAR: n_clear_req++;
          default:   n_other_req++;
        endcase
        if (n_distinct > peak_distinct) peak_distinct = n_distinct;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.entry_index    = m_axis_tdata[ENT_LSB +: ENTRY_W];
        got.symbol_value   = m_axis_tdata[SYM_LSB +: SYM_W];
        got.occurrences    = m_axis_tdata[OCC_LSB +: CNT_W];
        got.distinct_count = m_axis_tdata[DCNT_LSB +: DCNT_W];
        got.total_count    = m_axis_tdata[TOT_LSB +: CNT_W];
        got.is_new         = m_axis_tuser[0];
        got.table_full     = m_axis_tuser[1];
        n_results++;
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: result word with no request pending", $time);
        end else begin
          want = pending_q.pop_front();
          check_field("entry_index", CNT_W'(want.entry_index), CNT_W'(got.entry_index));
          check_field("is_new", CNT_W'(want.is_new), CNT_W'(got.is_new));
          check_field("table_full", CNT_W'(want.table_full), CNT_W'(got.table_full));
          check_field("symbol_value", CNT_W'(want.symbol_value),
                      CNT_W'(got.symbol_value));
          check_field("occurrences", want.occurrences, got.occurrences);
          check_field("distinct_count", CNT_W'(want.distinct_count),
                      CNT_W'(got.distinct_count));
          check_field("total_count", want.total_count, got.total_count);
          if (got.is_new === 1'b1) n_new++;
          if (got.table_full === 1'b1) n_full++;
        end
      end
    end
  end

  // Receiver back-pressure, switching pattern every so often
  int pace_mode = PACE_FREE;
  int pace_left = 0;

  always @(posedge clk_i) begin
    if (pace_left == 0) begin
      pace_mode = $urandom_range(PACE_FREE, PACE_SPARSE);
      pace_left = $urandom_range(50, 1500);
    end
    pace_left--;
    case (pace_mode)
      PACE_FREE: m_axis_tready <= 1'b1;
      PACE_HALF: m_axis_tready <= ($urandom_range(0, 1) == 0);
      default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic freq_result_t res(input logic [ENTRY_W-1:0] ent, input logic fresh,
                                       input logic full, input logic [SYM_W-1:0] sym,
                                       input logic [CNT_W-1:0] occ,
                                       input logic [DCNT_W-1:0] dcnt,
                                       input logic [CNT_W-1:0] tot);
    return '{ent, fresh, full, sym, occ, dcnt, tot};
  endfunction

  function automatic stim_row_t mk_row(input logic [REQ_W-1:0] req,
                                       input logic [SYM_W-1:0] sym,
                                       input logic [ENTRY_W-1:0] idx,
                                       input logic typed, input freq_result_t r);
    return '{req, sym, idx, typed, r};
  endfunction

  function automatic logic [SYM_W-1:0] random_symbol();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 21'h10FFFF;
      default: return SYM_W'($urandom);
    endcase
  endfunction

  // Present one word, hold until taken, then maybe close the burst
  task automatic drive_word(input stim_row_t w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({w.idx, w.sym});
    s_axis_tuser  <= w.req;
    word_typed    <= w.typed;
    word_res      <= w.typed_res;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_words++;
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(0, 9) < 7) repeat ($urandom_range(1, 4)) @(posedge clk_i);
      else repeat ($urandom_range(5, 300)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [SYM_W-1:0] sym,
                          input logic [ENTRY_W-1:0] idx);
    drive_word(mk_row(req, sym, idx, 1'b0, '0));
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Small symbol pool: mostly hits, some new symbols, reads, clears, junk codes
  task automatic run_pool_episode();
    logic [SYM_W-1:0] pool [$];
    int               pick;
    pool.delete();
    repeat ($urandom_range(1, 24)) pool.push_back(random_symbol());
    repeat ($urandom_range(20, 80)) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        send_req(REQ_COUNT, pool[$urandom_range(0, pool.size() - 1)],
                 ENTRY_W'($urandom));
      else if (pick < 70)
        send_req(REQ_COUNT, random_symbol(), ENTRY_W'($urandom));
      else if (pick < 80)
        send_req(REQ_READ, SYM_W'($urandom),
                 ENTRY_W'($urandom_range(0, n_distinct + 2)));
      else if (pick < 88)
        send_req(REQ_READ, SYM_W'($urandom), ENTRY_W'($urandom));
      else if (pick < 94)
        send_req(REQ_UNKNOWN, SYM_W'($urandom), ENTRY_W'($urandom));
      else
        send_req(REQ_CLEAR, SYM_W'($urandom), ENTRY_W'($urandom));
    end
  endtask

  // Fill the table to capacity, then hit it with drops, hits and reads
  task automatic run_fill_episode();
    logic [SYM_W-1:0] base, stride;
    base   = random_symbol();
    stride = SYM_W'($urandom | 1);   // odd stride keeps the walk distinct
    send_req(REQ_CLEAR, SYM_W'($urandom), ENTRY_W'($urandom));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_req(REQ_COUNT, SYM_W'(base + stride * i), ENTRY_W'($urandom));
      if ($urandom_range(0, 3) == 0)
        send_req(REQ_COUNT, SYM_W'(base + stride * $urandom_range(0, i)),
                 ENTRY_W'($urandom));
      if ($urandom_range(0, 19) == 0)
        send_req(REQ_READ, SYM_W'($urandom), ENTRY_W'($urandom));
    end
    repeat ($urandom_range(20, 40)) begin
      case ($urandom_range(0, 3))
        0:       send_req(REQ_COUNT, SYM_W'(base + stride * $urandom_range(256, 600)),
                          ENTRY_W'($urandom));
        1:       send_req(REQ_COUNT, SYM_W'(base + stride * $urandom_range(0, 255)),
                          ENTRY_W'($urandom));
        2:       send_req(REQ_READ, SYM_W'($urandom), ENTRY_W'($urandom));
        default: send_req(REQ_COUNT, random_symbol(), ENTRY_W'($urandom));
      endcase
    end
  endtask

  stim_row_t directed_q [$];
  int        episode = 0;

  initial begin
    // After reset, corner symbols, out-of-range reads, unknown code, clears
    directed_q.push_back(mk_row(REQ_READ, 21'h0, 8'd0, 1'b1, res(0, 0, 0, 0, 0, 0, 0)));
    directed_q.push_back(mk_row(REQ_READ, 21'h1FFFFF, 8'd255, 1'b1,
                                res(255, 0, 0, 0, 0, 0, 0)));
    directed_q.push_back(mk_row(REQ_UNKNOWN, 21'h1FFFFF, 8'hFF, 1'b1,
                                res(0, 0, 0, 0, 0, 0, 0)));
    directed_q.push_back(mk_row(REQ_CLEAR, 21'h1FFFFF, 8'hFF, 1'b1,
                                res(0, 0, 0, 0, 0, 0, 0)));
    directed_q.push_back(mk_row(REQ_COUNT, 21'h0, 8'hFF, 1'b1, res(0, 1, 0, 0, 1, 1, 1)));
    directed_q.push_back(mk_row(REQ_COUNT, 21'h1FFFFF, 8'h00, 1'b1,
                                res(1, 1, 0, 21'h1FFFFF, 1, 2, 2)));
    directed_q.push_back(mk_row(REQ_COUNT, 21'h0, 8'h00, 1'b1, res(0, 0, 0, 0, 2, 2, 3)));
    directed_q.push_back(mk_row(REQ_COUNT, 21'h10FFFF, 8'h00, 1'b1,
                                res(2, 1, 0, 21'h10FFFF, 1, 3, 4)));
    directed_q.push_back(mk_row(REQ_READ, 21'h1FFFFF, 8'd0, 1'b1, res(0, 0, 0, 0, 2, 3, 4)));
    directed_q.push_back(mk_row(REQ_READ, 21'h0, 8'd1, 1'b1,
                                res(1, 0, 0, 21'h1FFFFF, 1, 3, 4)));
    directed_q.push_back(mk_row(REQ_READ, 21'h0, 8'd3, 1'b1, res(3, 0, 0, 0, 0, 3, 4)));
    directed_q.push_back(mk_row(REQ_READ, 21'h0, 8'd255, 1'b1, res(255, 0, 0, 0, 0, 3, 4)));
    directed_q.push_back(mk_row(REQ_UNKNOWN, 21'h0, 8'd0, 1'b1, res(0, 0, 0, 0, 0, 3, 4)));
    directed_q.push_back(mk_row(REQ_COUNT, 21'h155555, 8'hAA, 1'b0, '0));
    directed_q.push_back(mk_row(REQ_COUNT, 21'h0AAAAA, 8'h55, 1'b0, '0));
    directed_q.push_back(mk_row(REQ_COUNT, 21'h155555, 8'h55, 1'b0, '0));
    directed_q.push_back(mk_row(REQ_READ, 21'h0AAAAA, 8'd4, 1'b0, '0));
    directed_q.push_back(mk_row(REQ_COUNT, 21'h1FFFFF, 8'hAA, 1'b0, '0));
    directed_q.push_back(mk_row(REQ_CLEAR, 21'h0, 8'd0, 1'b1, res(0, 0, 0, 0, 0, 0, 0)));
    // stale entries must not show through after a clear
    directed_q.push_back(mk_row(REQ_READ, 21'h0, 8'd0, 1'b1, res(0, 0, 0, 0, 0, 0, 0)));
    directed_q.push_back(mk_row(REQ_COUNT, 21'h0AAAAA, 8'h0F, 1'b1,
                                res(0, 1, 0, 21'h0AAAAA, 1, 1, 1)));
    directed_q.push_back(mk_row(REQ_READ, 21'h0, 8'd1, 1'b1, res(1, 0, 0, 0, 0, 1, 1)));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) drive_word(directed_q[i]);
    drain_results();

    // Random part: full-table episodes early and late, pool traffic between
    while (sent_words < ITEM_TARGET) begin
      episode++;
      if (episode == 1 || episode == 8 || $urandom_range(0, 14) == 0) run_fill_episode();
      else run_pool_episode();
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    drain_results();
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);

    $display("Run covered %0d requests: %0d count, %0d read, %0d clear, %0d unknown.",
             sent_words, n_count_req, n_read_req, n_clear_req, n_other_req);
    $display("%0d results checked: %0d new entries, %0d dropped on full table, peak %0d.",
             n_results, n_new, n_full, peak_distinct);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("Timeout with %0d results outstanding", pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
